// File: sv/pdrc_pkg.sv
// Shared types, constants and microcode for the ramped PID drive controller.
`timescale 1ns / 1ps
`default_nettype none

package pdrc_pkg;

    localparam int RAMP_STEPS_DEF = 20;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // input tdata layout
    localparam int IN_DIST_LSB    = 0;
    localparam int IN_TIMEOUT_LSB = 32;
    localparam int IN_MINCLR_LSB  = 52;
    localparam int IN_LEFT_LSB    = 68;
    localparam int IN_RIGHT_LSB   = 100;
    localparam int IN_OBJ_BIT     = 132;
    localparam int IN_RANGE_LSB   = 133;
    localparam int IN_NOW_LSB     = 149;

    // output tdata layout
    localparam int OUT_LEVEL_LSB = 0;
    localparam int OUT_REV_BIT   = 16;
    localparam int OUT_DONE_BIT  = 17;
    localparam int OUT_STEP_LSB  = 18;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_GAIN_P    = 3'd0;
    localparam cfg_idx_t CFG_GAIN_I    = 3'd1;
    localparam cfg_idx_t CFG_GAIN_D    = 3'd2;
    localparam cfg_idx_t CFG_STOP_TOL  = 3'd3;
    localparam cfg_idx_t CFG_FLOOR     = 3'd4;
    localparam cfg_idx_t CFG_CEILING   = 3'd5;

    localparam logic [23:0] GAIN_P_RST   = 24'd196608;
    localparam logic [23:0] GAIN_I_RST   = 24'd98;
    localparam logic [23:0] GAIN_D_RST   = 24'd5898;
    localparam logic [23:0] STOP_TOL_RST = 24'd6554;
    localparam logic [15:0] FLOOR_RST    = 16'd10240;
    localparam logic [15:0] CEILING_RST  = 16'd47104;

    localparam logic [31:0] INV_4PI_Q32   = 32'd341782638;
    localparam logic [15:0] OPEN_SPACE_Q8 = 16'd36864;
    localparam int          RECIP_SHIFT   = 32;
    localparam int          ACC_W         = 56;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_FETCH  = 4'd0;
    localparam pc_t PC_MEAN   = 4'd1;
    localparam pc_t PC_START  = 4'd2;
    localparam pc_t PC_CHECK  = 4'd3;
    localparam pc_t PC_ERR    = 4'd4;
    localparam pc_t PC_DIFF   = 4'd5;
    localparam pc_t PC_ACC_P  = 4'd6;
    localparam pc_t PC_ACC_IH = 4'd7;
    localparam pc_t PC_ACC_IL = 4'd8;
    localparam pc_t PC_ACC_D  = 4'd9;
    localparam pc_t PC_CLAMP  = 4'd10;
    localparam pc_t PC_RMUL   = 4'd11;
    localparam pc_t PC_RDIV   = 4'd12;
    localparam pc_t PC_RADD   = 4'd13;
    localparam pc_t PC_FINAL  = 4'd14;
    localparam pc_t PC_END    = 4'd15;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FETCH,
        OP_MEAN,
        OP_START,
        OP_ERR,
        OP_DIFF_SUM,
        OP_ACC_LOAD,
        OP_ACC_ADD_HI,
        OP_ACC_ADD_LO,
        OP_ACC_PMD,
        OP_CLAMP,
        OP_RAMP_ADD,
        OP_FINAL,
        OP_END
    } uop_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_INV,
        MUL_P,
        MUL_IHI,
        MUL_ILO,
        MUL_D,
        MUL_RAMP,
        MUL_RECIP
    } mul_sel_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_SAMPLE,
        COND_STOP,
        COND_NO_RAMP
    } cond_t;

    typedef struct packed {
        uop_t     op;
        mul_sel_t mul;
        cond_t    cond;
        pc_t      target;
        logic     emit;
    } uword_t;

    typedef struct packed {
        logic in_fire;
        logic out_stall;
        logic is_sample;
        logic stop;
        logic no_ramp;
    } useq_status_t;

    function automatic uword_t uc_rom(input pc_t pc);
        uword_t w;
        unique case (pc)
            PC_FETCH:  w = uword_t'{OP_FETCH,      MUL_NONE,  COND_NEVER,   PC_FETCH, 1'b0};
            PC_MEAN:   w = uword_t'{OP_MEAN,       MUL_INV,   COND_SAMPLE,  PC_CHECK, 1'b0};
            PC_START:  w = uword_t'{OP_START,      MUL_NONE,  COND_ALWAYS,  PC_FETCH, 1'b1};
            PC_CHECK:  w = uword_t'{OP_NONE,       MUL_NONE,  COND_STOP,    PC_END,   1'b0};
            PC_ERR:    w = uword_t'{OP_ERR,        MUL_NONE,  COND_NEVER,   PC_FETCH, 1'b0};
            PC_DIFF:   w = uword_t'{OP_DIFF_SUM,   MUL_P,     COND_NEVER,   PC_FETCH, 1'b0};
            PC_ACC_P:  w = uword_t'{OP_ACC_LOAD,   MUL_IHI,   COND_NEVER,   PC_FETCH, 1'b0};
            PC_ACC_IH: w = uword_t'{OP_ACC_ADD_HI, MUL_ILO,   COND_NEVER,   PC_FETCH, 1'b0};
            PC_ACC_IL: w = uword_t'{OP_ACC_ADD_LO, MUL_D,     COND_NEVER,   PC_FETCH, 1'b0};
            PC_ACC_D:  w = uword_t'{OP_ACC_PMD,    MUL_NONE,  COND_NEVER,   PC_FETCH, 1'b0};
            PC_CLAMP:  w = uword_t'{OP_CLAMP,      MUL_NONE,  COND_NEVER,   PC_FETCH, 1'b0};
            PC_RMUL:   w = uword_t'{OP_NONE,       MUL_RAMP,  COND_NO_RAMP, PC_FINAL, 1'b0};
            PC_RDIV:   w = uword_t'{OP_NONE,       MUL_RECIP, COND_NEVER,   PC_FETCH, 1'b0};
            PC_RADD:   w = uword_t'{OP_RAMP_ADD,   MUL_NONE,  COND_NEVER,   PC_FETCH, 1'b0};
            PC_FINAL:  w = uword_t'{OP_FINAL,      MUL_NONE,  COND_ALWAYS,  PC_FETCH, 1'b1};
            PC_END:    w = uword_t'{OP_END,        MUL_NONE,  COND_ALWAYS,  PC_FETCH, 1'b1};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: sv/pdrc_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module pdrc_useq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pdrc_pkg::useq_status_t status,
    output pdrc_pkg::uword_t       uword
);
    import pdrc_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;
    logic hold;

    assign uword = uc_rom(pc_reg);

    always_comb
    begin
        unique case (uword.cond)
            COND_NEVER:   take = 1'b0;
            COND_ALWAYS:  take = 1'b1;
            COND_SAMPLE:  take = status.is_sample;
            COND_STOP:    take = status.stop;
            COND_NO_RAMP: take = status.no_ramp;
            default:      take = 1'b0;
        endcase
    end

    assign hold = ((uword.op == OP_FETCH) && !status.in_fire) || status.out_stall;

    always_comb
    begin
        priority if (hold)
            pc_next = pc_reg;
        else if (take)
            pc_next = uword.target;
        else
            pc_next = pc_reg + pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_FETCH;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

// File: sv/pid_drive_ramped_controller_core.sv
// Top level of the ramped PID drive controller: datapath, output register, config.
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+-------------------------------
//  input    | s_axis_tvalid/tready/tdata[183:0]/tuser   | s_axis_tvalid & s_axis_tready
//  output   | m_axis_tvalid/tready/tdata[39:0]          | m_axis_tvalid & m_axis_tready
//  config   | cfg_valid/ready/index[2:0]/data[23:0]     | cfg_valid & cfg_ready
//
// One item at a time through a 16-word microprogram and one shared 33x32 multiplier.
// Start item: fetch, mean, start. Sample on stop or idle block: fetch, mean, check, end.
// Drive sample: PID steps, and while the ramp applies, a reciprocal-multiply divide.
// Reset clears the state at once; no clearing pass. The next item is taken while a
// result waits; the sequencer stalls only at its emit step if the output is still full.
`timescale 1ns / 1ps
`default_nettype none

module pid_drive_ramped_controller_core #(
    parameter int RAMP_STEPS = pdrc_pkg::RAMP_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // move_distance, timeout_ms, min_clearance, left_position, right_position,
    // object_seen, range_reading, now_ms, zero pad
    input  logic [pdrc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // drive_level, drive_reverse, move_done, step_number, zero pad
    output logic [pdrc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdrc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pdrc_pkg::*;

    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(RAMP_STEPS) + 64'd1;
    localparam logic [32:0] RECIP      = RECIP_FULL[32:0];

    uword_t       uword;
    useq_status_t status;

    logic [23:0] gain_p_reg, gain_i_reg, gain_d_reg, stop_tol_reg;
    logic [15:0] floor_reg, ceiling_reg;

    logic        cmd_reg;
    logic [31:0] dist_reg;
    logic [19:0] timeout_reg;
    logic [15:0] minclr_reg;
    logic [31:0] left_reg, right_reg;
    logic        obj_reg;
    logic [15:0] range_reg;
    logic [31:0] now_reg;

    logic signed [31:0] target_reg;
    logic [31:0]        start_time_reg;
    logic [19:0]        time_limit_reg;
    logic [15:0]        cl_limit_reg;
    logic [15:0]        clearance_reg;
    logic [31:0]        prev_err_reg;
    logic [47:0]        err_sum_reg;
    logic [15:0]        step_reg;
    logic               moving_reg;

    logic signed [32:0]      mean_reg;
    logic [31:0]             err_reg;
    logic                    rev_reg;
    logic [31:0]             dmag_reg;
    logic                    diff_pos_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [15:0]             level_reg;
    logic [64:0]             prod_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic in_fire, out_stall, emit_go;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_res;

    logic [32:0]        dist_ext, dist_mag;
    logic signed [32:0] lr_sum;
    logic [64:0]        prod_rnd;
    logic [32:0]        turns;
    logic signed [34:0] turns_s, t_sum;
    logic signed [31:0] target_next;
    logic signed [33:0] es;
    logic [33:0]        em;
    logic [31:0]        err_next;
    logic [32:0]        diff;
    logic [32:0]        diff_neg;
    logic [48:0]        sum_add;
    logic [ACC_W-1:0]   term_shr20, term_shl4;
    logic signed [ACC_W-1:0] floor_s, ceil_s;
    logic [15:0]        clamp_level, level_minus_floor, step_inc;
    logic [31:0]        elapsed;
    logic               stop_cond;

    pdrc_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    assign s_axis_tready = (uword.op == OP_FETCH);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_stall     = uword.emit && out_valid_reg && !m_axis_tready;
    assign emit_go       = uword.emit && !out_stall;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // end-of-move check
    assign elapsed   = now_reg - start_time_reg;
    assign stop_cond = !moving_reg
                    || ((step_reg != 16'd0) && (prev_err_reg <= {8'd0, stop_tol_reg}))
                    || (elapsed >= {12'd0, time_limit_reg})
                    || (clearance_reg < cl_limit_reg);

    assign status.in_fire   = in_fire;
    assign status.out_stall = out_stall;
    assign status.is_sample = cmd_reg;
    assign status.stop      = stop_cond;
    assign status.no_ramp   = !((step_reg < 16'(RAMP_STEPS)) && (level_reg > floor_reg));

    // start arithmetic
    assign dist_ext    = {dist_reg[31], dist_reg};
    assign dist_mag    = dist_reg[31] ? (33'd0 - dist_ext) : dist_ext;
    assign lr_sum      = $signed({left_reg[31], left_reg}) + $signed({right_reg[31], right_reg});
    assign prod_rnd    = prod_reg + 65'h0_8000_0000;
    assign turns       = prod_rnd[64:32];
    assign turns_s     = dist_reg[31] ? (35'sd0 - $signed({2'b00, turns}))
                                      : $signed({2'b00, turns});
    assign t_sum       = turns_s + $signed({{2{mean_reg[32]}}, mean_reg});
    assign target_next = (t_sum[34:31] == 4'b0000 || t_sum[34:31] == 4'b1111)
                       ? t_sum[31:0]
                       : (t_sum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // error terms
    assign es       = $signed({{2{target_reg[31]}}, target_reg}) - $signed({mean_reg[32], mean_reg});
    assign em       = es[33] ? (34'd0 - es) : es;
    assign err_next = (em[33:32] != 2'b00) ? 32'hFFFF_FFFF : em[31:0];
    assign diff     = {1'b0, err_reg} - {1'b0, prev_err_reg};
    assign diff_neg = 33'd0 - diff;
    assign sum_add  = {1'b0, err_sum_reg} + 49'(err_reg);

    assign term_shr20 = ACC_W'(prod_reg >> 20);
    assign term_shl4  = ACC_W'(prod_reg << 4);
    assign floor_s    = $signed(ACC_W'(floor_reg));
    assign ceil_s     = $signed(ACC_W'(ceiling_reg));

    always_comb
    begin
        priority if (acc_reg < floor_s)
            clamp_level = floor_reg;
        else if (acc_reg > ceil_s)
            clamp_level = ceiling_reg;
        else
            clamp_level = acc_reg[15:0];
    end

    assign level_minus_floor = level_reg - floor_reg;
    assign step_inc          = (step_reg == 16'hFFFF) ? step_reg : step_reg + 16'd1;

    // shared multiplier
    always_comb
    begin
        unique case (uword.mul)
            MUL_NONE:  begin mul_a = '0;                       mul_b = '0;                    end
            MUL_INV:   begin mul_a = dist_mag;                 mul_b = INV_4PI_Q32;           end
            MUL_P:     begin mul_a = {9'd0, gain_p_reg};       mul_b = err_reg;               end
            MUL_IHI:   begin mul_a = {9'd0, gain_i_reg};       mul_b = {8'd0, err_sum_reg[47:24]}; end
            MUL_ILO:   begin mul_a = {9'd0, gain_i_reg};       mul_b = {8'd0, err_sum_reg[23:0]};  end
            MUL_D:     begin mul_a = {9'd0, gain_d_reg};       mul_b = dmag_reg;              end
            MUL_RAMP:  begin mul_a = {17'd0, level_minus_floor}; mul_b = {16'd0, step_reg};   end
            MUL_RECIP: begin mul_a = RECIP;                    mul_b = {8'd0, prod_reg[23:0]}; end
        endcase
    end

    assign mul_res = 65'(mul_a) * 65'(mul_b);

    always_ff @(posedge clk)
    begin
        if (uword.mul != MUL_NONE)
            prod_reg <= mul_res;
    end

    // result word
    always_comb
    begin
        out_data_next = '0;
        case (uword.op)
            OP_FINAL:
            begin
                out_data_next[OUT_LEVEL_LSB +: 16] = level_reg;
                out_data_next[OUT_REV_BIT]         = rev_reg;
                out_data_next[OUT_STEP_LSB +: 16]  = step_inc;
            end
            OP_END:
            begin
                out_data_next[OUT_DONE_BIT]        = 1'b1;
                out_data_next[OUT_STEP_LSB +: 16]  = step_reg;
            end
            default:
            begin
                out_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_go)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
            out_data_reg <= out_data_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= GAIN_P_RST;
            gain_i_reg   <= GAIN_I_RST;
            gain_d_reg   <= GAIN_D_RST;
            stop_tol_reg <= STOP_TOL_RST;
            floor_reg    <= FLOOR_RST;
            ceiling_reg  <= CEILING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAIN_P:   gain_p_reg   <= cfg_data;
                CFG_GAIN_I:   gain_i_reg   <= cfg_data;
                CFG_GAIN_D:   gain_d_reg   <= cfg_data;
                CFG_STOP_TOL: stop_tol_reg <= cfg_data;
                CFG_FLOOR:    floor_reg    <= cfg_data[15:0];
                CFG_CEILING:  ceiling_reg  <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg     <= s_axis_tuser;
            dist_reg    <= s_axis_tdata[IN_DIST_LSB +: 32];
            timeout_reg <= s_axis_tdata[IN_TIMEOUT_LSB +: 20];
            minclr_reg  <= s_axis_tdata[IN_MINCLR_LSB +: 16];
            left_reg    <= s_axis_tdata[IN_LEFT_LSB +: 32];
            right_reg   <= s_axis_tdata[IN_RIGHT_LSB +: 32];
            obj_reg     <= s_axis_tdata[IN_OBJ_BIT];
            range_reg   <= s_axis_tdata[IN_RANGE_LSB +: 16];
            now_reg     <= s_axis_tdata[IN_NOW_LSB +: 32];
        end
    end

    // datapath scratch registers
    always_ff @(posedge clk)
    begin
        case (uword.op)
            OP_MEAN:       mean_reg  <= {lr_sum[32], lr_sum[32:1]};
            OP_ERR:
            begin
                err_reg <= err_next;
                rev_reg <= es[33];
            end
            OP_DIFF_SUM:
            begin
                diff_pos_reg <= !diff[32] && (diff != 33'd0);
                dmag_reg     <= diff[32] ? diff_neg[31:0] : diff[31:0];
            end
            OP_ACC_LOAD:   acc_reg   <= $signed(term_shr20);
            OP_ACC_ADD_HI: acc_reg   <= acc_reg + $signed(term_shl4);
            OP_ACC_ADD_LO: acc_reg   <= acc_reg + $signed(term_shr20);
            OP_ACC_PMD:    acc_reg   <= diff_pos_reg ? acc_reg - $signed(term_shr20)
                                                     : acc_reg + $signed(term_shr20);
            OP_CLAMP:      level_reg <= clamp_level;
            OP_RAMP_ADD:   level_reg <= floor_reg + prod_reg[RECIP_SHIFT +: 16];
            default:       ;
        endcase
    end

    // move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            start_time_reg <= '0;
            time_limit_reg <= '0;
            cl_limit_reg   <= '0;
            clearance_reg  <= OPEN_SPACE_Q8;
            prev_err_reg   <= '0;
            err_sum_reg    <= '0;
            step_reg       <= '0;
            moving_reg     <= 1'b0;
        end
        else if (!out_stall)
        begin
            case (uword.op)
                OP_START:
                begin
                    target_reg     <= target_next;
                    start_time_reg <= now_reg;
                    time_limit_reg <= timeout_reg;
                    cl_limit_reg   <= minclr_reg;
                    clearance_reg  <= obj_reg ? range_reg : OPEN_SPACE_Q8;
                    prev_err_reg   <= '0;
                    err_sum_reg    <= '0;
                    step_reg       <= '0;
                    moving_reg     <= 1'b1;
                end
                OP_DIFF_SUM:
                begin
                    err_sum_reg <= sum_add[48] ? 48'hFFFF_FFFF_FFFF : sum_add[47:0];
                end
                OP_FINAL:
                begin
                    prev_err_reg <= err_reg;
                    step_reg     <= step_inc;
                    if (obj_reg)
                        clearance_reg <= range_reg;
                end
                OP_END:
                begin
                    moving_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/pdrc_checker.sv
// Port-level checks for the ramped PID drive controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pdrc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pdrc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pdrc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a finished move reports no drive
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_DONE_BIT]
            |-> m_axis_tdata[OUT_REV_BIT:OUT_LEVEL_LSB] == 17'd0)
        else $error("drive reported on a done result");

    // step zero without done is the start acknowledge: no drive
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_DONE_BIT]
            && m_axis_tdata[OUT_STEP_LSB +: 16] == 16'd0
            |-> m_axis_tdata[OUT_REV_BIT:OUT_LEVEL_LSB] == 17'd0)
        else $error("drive reported at step zero");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

endmodule

bind pid_drive_ramped_controller_core pdrc_checker u_pdrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
